// ===== rtl/sad3s_pkg.sv =====
// Shared constants, types and helpers for the 3x3 shift SAD accumulator.
`default_nettype none

package sad3s_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  // Register defaults
  localparam int unsigned DEF_WIDTH  = 640;
  localparam int unsigned DEF_HEIGHT = 480;

  // Field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned REGI_W = 2;
  localparam int unsigned NSUM   = 9;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_W  = 24;
  localparam int unsigned OUT_W = 40;

  // Configuration register indexes
  typedef enum logic [REGI_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MASK_ENABLE  = 2'd2,
    REG_MASK_INDEX   = 2'd3
  } cfg_reg_t;

  // Control carried with an item through the first pipeline stage
  typedef struct packed {
    logic             vld;
    logic             frame_end;
    logic             inner;
    logic             par;
    logic [PIX_W-1:0] back;
  } s1_ctl_t;

  // Control carried with an item into the accumulate stage
  typedef struct packed {
    logic vld;
    logic frame_end;
    logic add;
  } s2_ctl_t;

  // Clamp a size register to 3..hi and return size minus one
  function automatic int unsigned clamp_m1(input logic [CFG_W-1:0] v, input int unsigned hi);
    int unsigned vv;
    vv = int'(v);
    if (vv < 3) begin
      return 2;
    end
    if (vv > hi) begin
      return hi - 1;
    end
    return vv - 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sad3s_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
`default_nettype none

module sad3s_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sad_3x3_shift_sums.sv =====
// Top level: 3x3 shift sum-of-absolute-differences accumulator over a pixel stream.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+--------------------------------------
//  s_axis   | in  | tvalid / tready        | tdata: cur_pixel, back_pixel, mask_value
//  m_axis   | out | tvalid / tready        | tdata: offset_index, sum_value; tlast
//  cfg      | in  | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// One pixel is taken per clock. The line stores are three RAMs (two background
// rows, one current row) read and written at the pixel's column in the cycle of
// the transaction; a window stage and an accumulate stage follow, and the first of
// a frame's nine sums is offered once its last pixel has passed the RAM read, window
// and accumulate registers, then one per cycle while the receiver accepts.
// Reset clears counters, sums and pipeline valids; the RAMs are not cleared.
// The input stalls only when a frame's last pixel arrives before the previous
// frame's nine results have all been taken.
`default_nettype none

module sad_3x3_shift_sums (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // slave stream
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // [7:0] cur_pixel, [15:8] back_pixel, [23:16] mask_value
  input  wire logic [sad3s_pkg::IN_W-1:0]      s_axis_tdata,
  // master stream
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [3:0] offset_index, [35:4] sum_value, [39:36] zero
  output      logic [sad3s_pkg::OUT_W-1:0]     m_axis_tdata,
  output      logic                            m_axis_tlast,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [sad3s_pkg::REGI_W-1:0]    cfg_index,
  input  wire logic [sad3s_pkg::CFG_W-1:0]     cfg_data
);

  localparam int unsigned PW = sad3s_pkg::PIX_W;
  localparam int unsigned SW = sad3s_pkg::SUM_W;
  localparam int unsigned CW = sad3s_pkg::COL_W;
  localparam int unsigned RW = sad3s_pkg::ROW_W;
  localparam int unsigned N  = sad3s_pkg::NSUM;

  // Configuration registers
  logic [CW-1:0] width_m1;
  logic [RW-1:0] height_m1;
  logic          mask_enable;
  logic [PW-1:0] mask_index;

  // Raster position
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;

  // Input fields
  logic [PW-1:0] cur_pixel;
  logic [PW-1:0] back_pixel;
  logic [PW-1:0] mask_value;

  logic in_acc;
  logic row_end;
  logic frame_end;
  logic sel;
  logic par;

  // RAM ports
  logic [PW-1:0]   back0_rd;
  logic [PW-1:0]   back1_rd;
  logic [PW:0]     center_rd;

  // Pipeline
  sad3s_pkg::s1_ctl_t s1;
  sad3s_pkg::s2_ctl_t s2;
  logic [PW:0]        center_hold;
  logic [PW-1:0]      win      [3][3];
  logic [PW-1:0]      win_next [3][3];
  logic [PW-1:0]      diff_next [N];
  logic [PW-1:0]      diff      [N];
  logic               add_next;

  // Sums and output shadow
  logic [SW-1:0] sums    [N];
  logic [SW-1:0] acc_val [N];
  logic [SW-1:0] shadow  [N];
  logic [sad3s_pkg::IDX_W-1:0] out_idx;
  logic          out_busy;
  logic          out_acc;

  assign cur_pixel  = s_axis_tdata[PW-1:0];
  assign back_pixel = s_axis_tdata[2*PW-1:PW];
  assign mask_value = s_axis_tdata[3*PW-1:2*PW];

  assign row_end   = (column_count >= width_m1);
  assign frame_end = row_end && (row_count >= height_m1);
  assign par       = row_count[0];
  assign sel       = !mask_enable || (mask_value == mask_index);

  // Hold a frame-end pixel while the previous frame's results are still pending
  assign s_axis_tready = !(frame_end && (out_busy || s1.frame_end || s2.frame_end));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration writes, sizes stored clamped and minus one
  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1    <= CW'(sad3s_pkg::DEF_WIDTH - 1);
      height_m1   <= RW'(sad3s_pkg::DEF_HEIGHT - 1);
      mask_enable <= 1'b0;
      mask_index  <= '0;
    end else if (cfg_wr_en) begin
      unique case (sad3s_pkg::cfg_reg_t'(cfg_index))
        sad3s_pkg::REG_FRAME_WIDTH: begin
          width_m1 <= CW'(sad3s_pkg::clamp_m1(cfg_data, sad3s_pkg::MAX_WIDTH));
        end
        sad3s_pkg::REG_FRAME_HEIGHT: begin
          height_m1 <= RW'(sad3s_pkg::clamp_m1(cfg_data, sad3s_pkg::MAX_HEIGHT));
        end
        sad3s_pkg::REG_MASK_ENABLE: begin
          mask_enable <= cfg_data[0];
        end
        sad3s_pkg::REG_MASK_INDEX: begin
          mask_index <= cfg_data[PW-1:0];
        end
      endcase
    end
  end

  // Advance the raster position on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        column_count <= '0;
        if (row_count >= height_m1) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + RW'(1);
        end
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Line stores: read old row and write new pixel at the same column.
  // Consecutive pixels touch different columns, so no forwarding is needed.
  sad3s_ram #(.WIDTH(PW), .DEPTH(sad3s_pkg::MAX_WIDTH)) u_back0 (
    .clk   (clk),
    .we    (in_acc && !par),
    .waddr (column_count),
    .wdata (back_pixel),
    .raddr (column_count),
    .rdata (back0_rd)
  );

  sad3s_ram #(.WIDTH(PW), .DEPTH(sad3s_pkg::MAX_WIDTH)) u_back1 (
    .clk   (clk),
    .we    (in_acc && par),
    .waddr (column_count),
    .wdata (back_pixel),
    .raddr (column_count),
    .rdata (back1_rd)
  );

  sad3s_ram #(.WIDTH(PW + 1), .DEPTH(sad3s_pkg::MAX_WIDTH)) u_center (
    .clk   (clk),
    .we    (in_acc),
    .waddr (column_count),
    .wdata ({sel, cur_pixel}),
    .raddr (column_count),
    .rdata (center_rd)
  );

  // Stage 1 control: capture the item alongside the RAM reads
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld       <= 1'b0;
      s1.frame_end <= 1'b0;
    end else begin
      s1.vld       <= in_acc;
      s1.frame_end <= in_acc && frame_end;
    end
    s1.inner <= (column_count >= CW'(2)) && (row_count >= RW'(2));
    s1.par   <= par;
    s1.back  <= back_pixel;
  end

  // Shift the window one column and load the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = s1.par ? back1_rd : back0_rd;
    win_next[1][2] = s1.par ? back0_rd : back1_rd;
    win_next[2][2] = s1.back;
  end

  // Absolute differences of the held center pixel against the new window
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (center_hold[PW-1:0] > win_next[r][c]) begin
          diff_next[r*3+c] = center_hold[PW-1:0] - win_next[r][c];
        end else begin
          diff_next[r*3+c] = win_next[r][c] - center_hold[PW-1:0];
        end
      end
    end
    add_next = s1.inner && center_hold[PW];
  end

  // Stage 1 update: window, center delay, differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld       <= 1'b0;
      s2.frame_end <= 1'b0;
    end else begin
      s2.vld       <= s1.vld;
      s2.frame_end <= s1.frame_end;
    end
    s2.add <= add_next;
    if (s1.vld) begin
      win         <= win_next;
      center_hold <= center_rd;
    end
    diff <= diff_next;
  end

  // Saturating accumulate
  always_comb begin
    logic [SW:0] s;
    for (int k = 0; k < N; k++) begin
      s = {1'b0, sums[k]} + (SW + 1)'(diff[k]);
      if (!s2.add) begin
        acc_val[k] = sums[k];
      end else if (s[SW]) begin
        acc_val[k] = '1;
      end else begin
        acc_val[k] = s[SW-1:0];
      end
    end
  end

  // Stage 2: accumulate, or hand the frame's sums to the output shadow and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        sums[k] <= '0;
      end
    end else if (s2.vld) begin
      for (int k = 0; k < N; k++) begin
        sums[k] <= s2.frame_end ? '0 : acc_val[k];
      end
    end
  end

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Output shadow: load at frame end, shift one sum per output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else if (s2.vld && s2.frame_end) begin
      out_busy <= 1'b1;
      out_idx  <= '0;
    end else if (out_acc) begin
      if (out_idx == sad3s_pkg::IDX_W'(N - 1)) begin
        out_busy <= 1'b0;
        out_idx  <= '0;
      end else begin
        out_idx <= out_idx + sad3s_pkg::IDX_W'(1);
      end
    end
    if (s2.vld && s2.frame_end) begin
      shadow <= acc_val;
    end else if (out_acc) begin
      for (int k = 0; k < N - 1; k++) begin
        shadow[k] <= shadow[k+1];
      end
    end
  end

  assign m_axis_tvalid = out_busy;
  assign m_axis_tdata  = {(sad3s_pkg::OUT_W - SW - sad3s_pkg::IDX_W)'(0), shadow[0], out_idx};
  assign m_axis_tlast  = (out_idx == sad3s_pkg::IDX_W'(N - 1));

  // A frame end reaching the accumulator always finds the shadow free
  a_shadow_free: assert property (@(posedge clk) disable iff (rst)
    (s2.vld && s2.frame_end) |-> !out_busy)
    else $error("frame end reached accumulator while results pending");

  // A frame end starts result output on the next cycle
  a_out_start: assert property (@(posedge clk) disable iff (rst)
    (s2.vld && s2.frame_end) |=> (m_axis_tvalid && out_idx == '0))
    else $error("results did not start after frame end");

  // A frame-end pixel is only taken when the shadow is free
  a_end_gate: assert property (@(posedge clk) disable iff (rst)
    (in_acc && frame_end) |-> !out_busy)
    else $error("frame-end pixel taken while results pending");

  // The ninth result closes the output burst
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (out_acc && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output still valid after last result");

endmodule

`default_nettype wire
